// ===== src/cpvpi_pkg.sv =====
package cpvpi_pkg;

	// item kinds carried in the low bits of s_tuser
	localparam logic [1:0] OP_STEP  = 2'd0;
	localparam logic [1:0] OP_MODE  = 2'd1;
	localparam logic [1:0] OP_RESET = 2'd2;

	// control modes carried in the high bits of s_tuser
	localparam logic [1:0] MODE_TORQUE   = 2'd0;
	localparam logic [1:0] MODE_VELOCITY = 2'd1;
	localparam logic [1:0] MODE_POSITION = 2'd2;

	// register indexes on the configuration port
	typedef enum logic [2:0] {
		REG_VEL_KP,
		REG_VEL_KI_STEP,
		REG_INTEGRAL_LIMIT,
		REG_POS_KP,
		REG_VEL_LIMIT
	} reg_idx_t;

	// register reset values, Q16.16
	localparam logic [30:0] RST_INTEGRAL_LIMIT = 31'd1572864;
	localparam logic [31:0] RST_POS_KP         = 32'd655360;
	localparam logic [30:0] RST_VEL_LIMIT      = 31'd655360;

	// fraction bits of the gains
	localparam int FRAC_Q16 = 16;
	localparam int FRAC_Q24 = 24;

	// which gain the shared multiplier uses
	typedef enum logic [1:0] {
		GAIN_POS,
		GAIN_KI,
		GAIN_KP
	} gain_sel_t;

	typedef struct packed {
		logic      en;
		gain_sel_t sel;
	} mul_ctl_t;

endpackage

// ===== src/cascaded_position_velocity_pi.sv =====
// Cascaded position / velocity PI controller giving a quadrature voltage command.
// Input words arrive on s_tvalid/s_tready: s_tuser holds opcode and mode, s_tdata
// holds target, measured velocity and measured angle (all signed Q16.16).
// A control step gives one result word on m_tvalid/m_tready with the voltage
// command, the last velocity target and a wrapping sequence count. Mode change
// and reset words update the state and give no result.
// Gains and limits are to be written only while the block is idle; it does not enforce this.
// In torque or other mode a step goes straight to the output state; velocity mode
// first runs error, multiply, round, integrate, multiply, round and sum, and position
// mode adds error, multiply, round and clamp before those. The block takes one word
// at a time and s_tready is low while a step is computed. The steps are set by the
// single 32x32 multiplier, used three times in position mode and twice in velocity
// mode, each use followed by a rounding state. s_tready returns the cycle after a
// result is loaded; mode change and reset words are taken every cycle.
// Results sit in an output register: the next word is accepted while a result
// waits, and a finished step holds in its last state until the register is free.
// Reset clears integral, velocity target, sequence count and loads the default
// gains and limits; no result is given during reset, though s_tready is high then and an offered word is ignored.
module cascaded_position_velocity_pi
	import cpvpi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [3:0]  s_tuser,  // opcode[1:0], mode[3:2]
	input  logic [95:0] s_tdata,  // target[31:0], measured_velocity[63:32], measured_angle[95:64]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,  // volt_cmd[31:0], velocity_target[63:32], sequence_res[95:64]
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PERR,
		ST_PMUL,
		ST_PRND,
		ST_PCLP,
		ST_VERR,
		ST_IMUL,
		ST_IRND,
		ST_IACC,
		ST_KMUL,
		ST_KRND,
		ST_SUM,
		ST_OUT
	} state_t;

	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		if (v[32] != v[31]) sat33 = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		else                sat33 = v[31:0];
	endfunction

	function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] d;
		d = {a[31], a} - {b[31], b};
		sub_sat = sat33(d);
	endfunction

	function automatic logic signed [31:0] clamp_lim(input logic signed [32:0] v,
			input logic [30:0] lim);
		logic signed [32:0] l;
		logic signed [32:0] nl;
		l  = {2'b00, lim};
		nl = -l;
		if (v > l)       clamp_lim = l[31:0];
		else if (v < nl) clamp_lim = nl[31:0];
		else             clamp_lim = v[31:0];
	endfunction

	state_t             state_q;
	logic [31:0]        vel_kp_q;
	logic [31:0]        vel_ki_q;
	logic [30:0]        int_lim_q;
	logic [31:0]        pos_kp_q;
	logic [30:0]        vel_lim_q;
	logic signed [31:0] integral_q;
	logic signed [31:0] last_vt_q;
	logic [31:0]        seq_q;
	logic [1:0]         mode_q;
	logic signed [31:0] target_q;
	logic signed [31:0] meas_vel_q;
	logic signed [31:0] meas_ang_q;
	logic signed [31:0] err_q;
	logic signed [31:0] tmp_q;
	logic signed [31:0] volt_q;
	logic               m_valid_q;
	logic [95:0]        m_data_q;
	logic               s_acc;
	logic [1:0]         in_op;
	logic [1:0]         in_mode;
	logic signed [31:0] vel_src;
	logic signed [31:0] mul_res;
	mul_ctl_t           mul_ctl;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign in_op    = s_tuser[1:0];
	assign in_mode  = s_tuser[3:2];
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign vel_src  = (mode_q == MODE_VELOCITY) ? target_q : last_vt_q;

	// multiplier control from the sequencer
	always_comb begin
		mul_ctl.en  = 1'b0;
		mul_ctl.sel = GAIN_KP;
		case (state_q)
			ST_PMUL: begin
				mul_ctl.en  = 1'b1;
				mul_ctl.sel = GAIN_POS;
			end
			ST_IMUL: begin
				mul_ctl.en  = 1'b1;
				mul_ctl.sel = GAIN_KI;
			end
			ST_KMUL: begin
				mul_ctl.en  = 1'b1;
				mul_ctl.sel = GAIN_KP;
			end
			default: mul_ctl.en = 1'b0;
		endcase
	end

	cpvpi_gain_mul u_mul (
		.clk         (clk),
		.ctl         (mul_ctl),
		.err         (err_q),
		.pos_kp      (pos_kp_q),
		.vel_ki_step (vel_ki_q),
		.vel_kp      (vel_kp_q),
		.res         (mul_res)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_kp_q  <= '0;
			vel_ki_q  <= '0;
			int_lim_q <= RST_INTEGRAL_LIMIT;
			pos_kp_q  <= RST_POS_KP;
			vel_lim_q <= RST_VEL_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VEL_KP:         vel_kp_q  <= cfg_data;
				REG_VEL_KI_STEP:    vel_ki_q  <= cfg_data;
				REG_INTEGRAL_LIMIT: int_lim_q <= cfg_data[30:0];
				REG_POS_KP:         pos_kp_q  <= cfg_data;
				REG_VEL_LIMIT:      vel_lim_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// input word latch
	always_ff @(posedge clk) begin
		if (s_acc) begin
			mode_q     <= in_mode;
			target_q   <= s_tdata[31:0];
			meas_vel_q <= s_tdata[63:32];
			meas_ang_q <= s_tdata[95:64];
		end
	end

	// working registers along the step
	always_ff @(posedge clk) begin
		case (state_q)
			ST_PERR: err_q  <= sub_sat(target_q, meas_ang_q);
			ST_VERR: err_q  <= sub_sat(vel_src, meas_vel_q);
			ST_PRND: tmp_q  <= mul_res;
			ST_IRND: tmp_q  <= mul_res;
			ST_KRND: tmp_q  <= mul_res;
			default: ;
		endcase
	end

	// sequencer, controller state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			integral_q <= '0;
			last_vt_q  <= '0;
			seq_q      <= '0;
			volt_q     <= '0;
			m_valid_q  <= 1'b0;
			m_data_q   <= '0;
		end else begin
			// output taken; a step loading its result reloads valid itself
			if (m_valid_q && m_tready && (state_q != ST_OUT)) m_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						case (in_op)
							OP_STEP: begin
								case (in_mode)
									MODE_TORQUE: begin
										volt_q  <= s_tdata[31:0];
										state_q <= ST_OUT;
									end
									MODE_VELOCITY: state_q <= ST_VERR;
									MODE_POSITION: state_q <= ST_PERR;
									default: begin
										volt_q  <= '0;
										state_q <= ST_OUT;
									end
								endcase
							end
							OP_MODE: integral_q <= '0;
							OP_RESET: begin
								integral_q <= '0;
								last_vt_q  <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_PERR: state_q <= ST_PMUL;
				ST_PMUL: state_q <= ST_PRND;
				ST_PRND: state_q <= ST_PCLP;
				ST_PCLP: begin
					last_vt_q <= clamp_lim({tmp_q[31], tmp_q}, vel_lim_q);
					state_q   <= ST_VERR;
				end
				ST_VERR: state_q <= ST_IMUL;
				ST_IMUL: state_q <= ST_IRND;
				ST_IRND: state_q <= ST_IACC;
				ST_IACC: begin
					integral_q <= clamp_lim({integral_q[31], integral_q} + {tmp_q[31], tmp_q},
						int_lim_q);
					state_q    <= ST_KMUL;
				end
				ST_KMUL: state_q <= ST_KRND;
				ST_KRND: state_q <= ST_SUM;
				ST_SUM: begin
					volt_q  <= sat33({tmp_q[31], tmp_q} + {integral_q[31], integral_q});
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					// wait for a free output register
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {seq_q + 32'd1, last_vt_q, volt_q};
						seq_q     <= seq_q + 32'd1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== src/cpvpi_gain_mul.sv =====
module cpvpi_gain_mul
	import cpvpi_pkg::*;
(
	input  logic               clk,
	input  mul_ctl_t           ctl,
	input  logic signed [31:0] err,
	input  logic [31:0]        pos_kp,
	input  logic [31:0]        vel_ki_step,
	input  logic [31:0]        vel_kp,
	output logic signed [31:0] res
);

	logic [31:0] err_u;
	logic [31:0] mag;
	logic [31:0] gain;
	logic [63:0] prod_q;
	logic        neg_q;
	logic        f24_q;
	logic [64:0] sum;
	logic [64:0] rnd;

	// magnitude of the error and gain select
	assign err_u = err;
	assign mag   = err_u[31] ? (~err_u + 32'd1) : err_u;

	always_comb begin
		case (ctl.sel)
			GAIN_POS: gain = pos_kp;
			GAIN_KI:  gain = vel_ki_step;
			GAIN_KP:  gain = vel_kp;
			default:  gain = vel_kp;
		endcase
	end

	// product register, 32x32 product with operands widened to the result
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			prod_q <= 64'(mag) * 64'(gain);
			neg_q  <= err_u[31];
			f24_q  <= (ctl.sel == GAIN_KI);
		end
	end

	// round half away from zero, then shift out the fraction
	assign sum = {1'b0, prod_q} + (f24_q ? (65'd1 << (FRAC_Q24 - 1)) : (65'd1 << (FRAC_Q16 - 1)));
	assign rnd = f24_q ? (sum >> FRAC_Q24) : (sum >> FRAC_Q16);

	// restore sign and saturate
	always_comb begin
		if (neg_q) begin
			if (rnd > 65'h0_8000_0000) res = 32'sh8000_0000;
			else                       res = ~rnd[31:0] + 32'd1;
		end else begin
			if (rnd > 65'h0_7FFF_FFFF) res = 32'sh7FFF_FFFF;
			else                       res = rnd[31:0];
		end
	end

endmodule

// ===== src/cpvpi_check.sv =====
module cpvpi_check
	import cpvpi_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [3:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata
);

	logic [31:0] last_seq_q;

	// sequence number of the last word taken on the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_seq_q <= '0;
		end else if (m_tvalid && m_tready) begin
			last_seq_q <= m_tdata[95:64];
		end
	end

	// a control step keeps the input closed while it is computed
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[1:0] == OP_STEP) |=> !s_tready)
		else $error("input still ready after a control step was taken");

	// mode change, reset and unused words give no result
	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[1:0] != OP_STEP) && !m_tvalid |=> !m_tvalid)
		else $error("result appeared for a word that is not a control step");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	// results are numbered one after another
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[95:64] == last_seq_q + 32'd1))
		else $error("sequence count skipped or repeated");

endmodule

bind cascaded_position_velocity_pi cpvpi_check u_check (.*);

// ===== tb/cascaded_position_velocity_pi_test.sv =====
`timescale 1ns / 1ps

module cascaded_position_velocity_pi_test
	import cpvpi_pkg::*;
();

	// codes the package leaves unnamed
	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam logic [1:0] MODE_OTHER = 2'd3;

	localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

	localparam int SETTLE_CYCLES = 24;
	localparam int CYCLE_LIMIT   = 600000;

	typedef struct {
		logic [1:0]        opcode;
		logic [1:0]        mode;
		logic signed [31:0] target;
		logic signed [31:0] meas_vel;
		logic signed [31:0] meas_angle;
	} ctrl_word_t;

	typedef struct {
		logic [31:0] volt_cmd;
		logic [31:0] velocity_target;
		logic [31:0] sequence_res;
	} voltage_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [3:0]  s_tuser = '0;   // opcode[1:0], mode[3:2]
	logic [95:0] s_tdata = '0;   // target[31:0], measured_velocity[63:32], measured_angle[95:64]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;        // volt_cmd[31:0], velocity_target[63:32], sequence_res[95:64]
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// controller copy: gains, limits and loop state
	logic [31:0]        gain_vel_kp;
	logic [31:0]        gain_vel_ki;
	logic [30:0]        lim_integral;
	logic [31:0]        gain_pos_kp;
	logic [30:0]        lim_vel;
	logic signed [31:0] integ;
	logic signed [31:0] vel_target_hold;
	logic [31:0]        step_count;

	voltage_cmd_t cmd_queue[$];
	int  mismatches = 0;
	int  cycle_count = 0;
	int  rx_hold_req = 0;
	bit  tx_jitter = 1'b1;
	bit  rx_jitter = 1'b1;

	cascaded_position_velocity_pi DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// saturate a wide value to a signed word
	function automatic logic signed [31:0] clip_word(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return Q_MAX;
		if (v < -64'sd2147483648) return Q_MIN;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] clip_diff(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] x;
		x = a;
		x = x - b;
		return clip_word(x);
	endfunction

	// unsigned gain times signed value, rounded half away from zero, saturated
	function automatic logic signed [31:0] apply_gain(input logic signed [31:0] a,
			input logic [31:0] gain, input int frac);
		logic signed [63:0] wide;
		logic [63:0] mag;
		logic [63:0] rounded;
		wide = a;
		mag = a[31] ? -wide : wide;
		rounded = (mag * {32'd0, gain} + (64'd1 << (frac - 1))) >> frac;
		if (a[31]) return (rounded > 64'h8000_0000) ? Q_MIN : -rounded[31:0];
		return (rounded > 64'h7fff_ffff) ? Q_MAX : rounded[31:0];
	endfunction

	// velocity PI with clamped integral
	function automatic logic signed [31:0] speed_pi(input logic signed [31:0] err);
		logic signed [63:0] acc;
		logic signed [63:0] bound;
		bound = {33'd0, lim_integral};
		acc = integ + apply_gain(err, gain_vel_ki, FRAC_Q24);
		if (acc > bound) acc = bound;
		if (acc < -bound) acc = -bound;
		integ = acc[31:0];
		return clip_word(apply_gain(err, gain_vel_kp, FRAC_Q16) + acc);
	endfunction

	// one accepted word: update state, return 1 when a command word follows
	function automatic bit compute_command(input ctrl_word_t w, output voltage_cmd_t r);
		logic signed [31:0] volt;
		logic signed [31:0] vt;
		logic signed [31:0] lv;
		r.volt_cmd = '0;
		r.velocity_target = '0;
		r.sequence_res = '0;
		volt = '0;
		lv = {1'b0, lim_vel};
		case (w.opcode)
			OP_STEP: ;
			OP_MODE: begin
				integ = '0;
				return 1'b0;
			end
			OP_RESET: begin
				integ = '0;
				vel_target_hold = '0;
				return 1'b0;
			end
			default: return 1'b0;
		endcase
		case (w.mode)
			MODE_TORQUE: volt = w.target;
			MODE_VELOCITY: volt = speed_pi(clip_diff(w.target, w.meas_vel));
			MODE_POSITION: begin
				vt = apply_gain(clip_diff(w.target, w.meas_angle), gain_pos_kp, FRAC_Q16);
				if (vt > lv) vt = lv;
				if (vt < -lv) vt = -lv;
				vel_target_hold = vt;
				volt = speed_pi(clip_diff(vt, w.meas_vel));
			end
			default: volt = '0;
		endcase
		step_count = step_count + 32'd1;
		r.volt_cmd = volt;
		r.velocity_target = vel_target_hold;
		r.sequence_res = step_count;
		return 1'b1;
	endfunction

	function automatic ctrl_word_t make_word(input logic [1:0] op, input logic [1:0] mode,
			input logic signed [31:0] tgt, input logic signed [31:0] vel,
			input logic signed [31:0] ang);
		ctrl_word_t w;
		w.opcode = op;
		w.mode = mode;
		w.target = tgt;
		w.meas_vel = vel;
		w.meas_angle = ang;
		return w;
	endfunction

	// mix of full range, small, medium and edge values
	function automatic logic signed [31:0] rand_q16();
		logic signed [31:0] v;
		case ($urandom_range(0, 3))
			0: v = $urandom;
			1: v = $urandom_range(0, 32'h0020_0000) - 32'sh0010_0000;
			2: v = $urandom_range(0, 32'h0800_0000) - 32'sh0400_0000;
			default: begin
				case ($urandom_range(0, 4))
					0: v = Q_MAX;
					1: v = Q_MIN;
					2: v = '0;
					3: v = -32'sd1;
					default: v = 32'sd1;
				endcase
			end
		endcase
		return v;
	endfunction

	function automatic ctrl_word_t random_word();
		ctrl_word_t w;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 85) w.opcode = OP_STEP;
		else if (pick < 91) w.opcode = OP_MODE;
		else if (pick < 96) w.opcode = OP_RESET;
		else w.opcode = OP_UNUSED;
		w.mode = 2'($urandom_range(0, 3));
		w.target = rand_q16();
		w.meas_vel = rand_q16();
		// keep the angle near the target now and then so the position loop stays linear
		w.meas_angle = ($urandom_range(0, 2) == 0)
			? w.target + ($urandom_range(0, 32'h0002_0000) - 32'sh0001_0000) : rand_q16();
		return w;
	endfunction

	function automatic logic [31:0] rand_gain(input bit q24);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 32'hffff_ffff;
			2: return $urandom;
			default: return q24 ? $urandom_range(0, 32'h0100_0000) : $urandom_range(0, 32'h0004_0000);
		endcase
	endfunction

	// bit 31 is not part of a limit and is toggled on purpose
	function automatic logic [31:0] rand_limit();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 32'hffff_ffff;
			2: return $urandom;
			default: return {1'($urandom_range(0, 1)), 31'($urandom_range(0, 32'h0040_0000))};
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns  %s: got %h want %h", $time, what, got, want);
		mismatches++;
	endtask

	// register write, model copy follows
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_VEL_KP:         gain_vel_kp = data;
			REG_VEL_KI_STEP:    gain_vel_ki = data;
			REG_INTEGRAL_LIMIT: lim_integral = data[30:0];
			REG_POS_KP:         gain_pos_kp = data;
			REG_VEL_LIMIT:      lim_vel = data[30:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic program_gains(input logic [31:0] kp, input logic [31:0] ki,
			input logic [31:0] ilim, input logic [31:0] pkp, input logic [31:0] vlim);
		write_reg(REG_VEL_KP, kp);
		write_reg(REG_VEL_KI_STEP, ki);
		write_reg(REG_INTEGRAL_LIMIT, ilim);
		write_reg(REG_POS_KP, pkp);
		write_reg(REG_VEL_LIMIT, vlim);
	endtask

	// drop valid, wait out pending commands and any word still in flight
	task automatic settle();
		s_tvalid <= 1'b0;
		while (cmd_queue.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// offer one word, predict on acceptance
	task automatic send_word(input ctrl_word_t w);
		voltage_cmd_t r;
		if (tx_jitter && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= {w.mode, w.opcode};
		s_tdata <= {w.meas_angle, w.meas_vel, w.target};
		do @(posedge clk); while (!s_tready);
		if (compute_command(w, r)) cmd_queue.push_back(r);
	endtask

	task automatic send_random(input int n);
		repeat (n) send_word(random_word());
	endtask

	// reset values, every mode and opcode, saturation, clamps and state clears
	task automatic test_directed();
		send_word(make_word(OP_STEP, MODE_POSITION, Q_ONE, 32'sd0, 32'sd0));
		send_word(make_word(OP_STEP, MODE_VELOCITY, 32'sd3 * Q_ONE, 32'sd0, 32'sd0));
		settle();
		program_gains(32'h0002_0000, 32'h0080_0000, 32'h0005_0000, 32'h000a_0000,
			32'h0003_0000);
		send_word(make_word(OP_STEP, MODE_TORQUE, Q_MAX, Q_MIN, Q_MAX));
		send_word(make_word(OP_STEP, MODE_TORQUE, Q_MIN, Q_MAX, Q_MIN));
		send_word(make_word(OP_STEP, MODE_TORQUE, 32'sd0, 32'sd0, 32'sd0));
		send_word(make_word(OP_STEP, MODE_OTHER, Q_MAX, Q_ONE, Q_ONE));
		send_word(make_word(OP_UNUSED, MODE_VELOCITY, Q_ONE, 32'sd0, 32'sd0));
		send_word(make_word(OP_STEP, MODE_VELOCITY, Q_MAX, Q_MIN, 32'sd0));
		send_word(make_word(OP_STEP, MODE_VELOCITY, Q_MIN, Q_MAX, 32'sd0));
		repeat (3) send_word(make_word(OP_STEP, MODE_VELOCITY, Q_ONE, 32'sd0, 32'sd0));
		send_word(make_word(OP_STEP, MODE_POSITION, Q_MAX, 32'sd0, Q_MIN));
		send_word(make_word(OP_STEP, MODE_POSITION, Q_MIN, Q_ONE, Q_MAX));
		send_word(make_word(OP_STEP, MODE_TORQUE, Q_ONE, 32'sd0, 32'sd0));
		send_word(make_word(OP_MODE, MODE_OTHER, Q_MAX, Q_MAX, Q_MAX));
		send_word(make_word(OP_STEP, MODE_VELOCITY, Q_ONE, 32'sd0, 32'sd0));
		send_word(make_word(OP_RESET, MODE_POSITION, Q_MIN, Q_MIN, Q_MIN));
		send_word(make_word(OP_STEP, MODE_TORQUE, -Q_ONE, 32'sd0, 32'sd0));
		// wind the integral up, then lower its limit under the stored value
		repeat (2) send_word(make_word(OP_STEP, MODE_VELOCITY, 32'sd4 * Q_ONE, 32'sd0, 32'sd0));
		settle();
		write_reg(REG_INTEGRAL_LIMIT, Q_ONE);
		send_word(make_word(OP_STEP, MODE_VELOCITY, 32'sd0, 32'sd0, 32'sd0));
	endtask

	// every register at zero, then at full scale
	task automatic test_gain_extremes();
		settle();
		program_gains('0, '0, '0, '0, '0);
		send_random(40);
		settle();
		program_gains(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'h7fff_ffff);
		send_random(40);
	endtask

	task automatic test_random_phases(input int phases, input int per_phase);
		repeat (phases) begin
			settle();
			program_gains(rand_gain(1'b0), rand_gain(1'b1), rand_limit(), rand_gain(1'b0),
				rand_limit());
			tx_jitter = ($urandom_range(0, 3) != 0);
			rx_jitter = ($urandom_range(0, 3) != 0);
			send_random(per_phase);
		end
		tx_jitter = 1'b1;
		rx_jitter = 1'b1;
	endtask

	// receiver holds off long enough for the block to stall its input
	task automatic test_output_backpressure();
		word_loop_steps: begin
			rx_hold_req = 250;
			repeat (25) begin
				ctrl_word_t w;
				w = random_word();
				w.opcode = OP_STEP;
				send_word(w);
			end
		end
	endtask

	// sender pauses until every command has come back
	task automatic test_drain_pause();
		send_random(20);
		s_tvalid <= 1'b0;
		while (cmd_queue.size() != 0) @(posedge clk);
		send_random(20);
	endtask

	task automatic test_steady_stream();
		tx_jitter = 1'b0;
		rx_jitter = 1'b0;
		send_random(100);
	endtask

	// receiver ready pattern
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (rx_hold_req > 0) begin
				n = rx_hold_req;
				rx_hold_req = 0;
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
				m_tready <= 1'b1;
			end else if (rx_jitter && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// compare each command word with the oldest prediction
	initial begin
		voltage_cmd_t want;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (cmd_queue.size() == 0) begin
					report_mismatch("command word with none pending", m_tdata[31:0], '0);
				end else begin
					want = cmd_queue.pop_front();
					if (m_tdata[31:0] !== want.volt_cmd)
						report_mismatch("volt_cmd", m_tdata[31:0], want.volt_cmd);
					if (m_tdata[63:32] !== want.velocity_target)
						report_mismatch("velocity_target", m_tdata[63:32], want.velocity_target);
					if (m_tdata[95:64] !== want.sequence_res)
						report_mismatch("sequence_res", m_tdata[95:64], want.sequence_res);
				end
			end
		end
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		gain_vel_kp = '0;
		gain_vel_ki = '0;
		lim_integral = RST_INTEGRAL_LIMIT;
		gain_pos_kp = RST_POS_KP;
		lim_vel = RST_VEL_LIMIT;
		integ = '0;
		vel_target_hold = '0;
		step_count = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_gain_extremes();
		test_random_phases(14, 100);
		test_output_backpressure();
		test_drain_pause();
		test_steady_stream();

		s_tvalid <= 1'b0;
		while (cmd_queue.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
